/* src/third_order_recursive_random_generator_core_assert.svh */
// Assertion macros for the third-order recursive random generator core.
`ifndef THIRD_ORDER_RECURSIVE_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define THIRD_ORDER_RECURSIVE_RANDOM_GENERATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TORRG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TORRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TORRG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TORRG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/torrg_pkg.sv */
// Constants, register indexes and modular helpers for the random generator core.
package torrg_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned ACC_W   = 50;   // three 48-bit products summed
  localparam int unsigned HIST_N  = 3;

  localparam logic [WORD_W-1:0] MODULUS        = 32'hFFFF_FFFB;  // 2^32 - 5
  localparam logic [WORD_W-1:0] HIST_RESET     = 32'd10;
  localparam logic [COEF_W-1:0] COEF_FIRST_RST  = 16'd1176;
  localparam logic [COEF_W-1:0] COEF_SECOND_RST = 16'd1476;
  localparam logic [COEF_W-1:0] COEF_THIRD_RST  = 16'd1176;
  localparam logic [WORD_W-1:0] SEED_RESET     = 32'd10;

  typedef enum logic [1:0] {
    REG_COEF_FIRST  = 2'd0,
    REG_COEF_SECOND = 2'd1,
    REG_COEF_THIRD  = 2'd2,
    REG_SEED_VALUE  = 2'd3
  } cfg_reg_t;

  typedef logic [WORD_W-1:0] word_t;

  // Bring a 32-bit word into [0, MODULUS).
  function automatic word_t fold_word(input word_t v);
    word_t r;
    r = (v >= MODULUS) ? v - MODULUS : v;
    return r;
  endfunction

  // acc mod (2^32-5), using 2^32 == 5 twice, then one compare and subtract.
  function automatic word_t mod_acc(input logic [ACC_W-1:0] acc);
    logic [WORD_W:0] s1;
    logic [WORD_W:0] s2;
    word_t           r;
    s1 = {1'b0, acc[WORD_W-1:0]} + 33'(acc[ACC_W-1:WORD_W]) * 33'd5;
    s2 = {1'b0, s1[WORD_W-1:0]} + (s1[WORD_W] ? 33'd5 : 33'd0);
    r  = (s2 >= {1'b0, MODULUS}) ? 32'(s2 - {1'b0, MODULUS}) : s2[WORD_W-1:0];
    return r;
  endfunction

endpackage

/* src/third_order_recursive_random_generator_core.sv */
// Third-order multiple recursive random generator modulo 2^32-5, stream in and out.
// One request item (tdata bit 0: 0 = advance, 1 = reseed) gives one 32-bit result
// item. The block takes one item per clock while the output is not stalled: the
// request sits in an input register while three 16x32 products, their sum and a
// fixed two-step fold modulo 2^32-5 form the next value, which enters the output
// register (whose valid bit is m_tvalid) and the three-word history at the same edge.
// Reseed loads all history words with the seed (less the modulus when the seed is
// at or above it) and returns it. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is idle,
// as the block itself does not enforce this.
`include "third_order_recursive_random_generator_core_assert.svh"

module third_order_recursive_random_generator_core
  import torrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] reseed, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] random_value
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [COEF_W-1:0] coef_first;
  logic [COEF_W-1:0] coef_second;
  logic [COEF_W-1:0] coef_third;
  word_t             seed_value;

  word_t             hist [HIST_N];
  logic              in_vld;
  logic              in_reseed;
  logic              out_vld;
  word_t             out_data;

  logic              adv;
  logic [ACC_W-1:0]  acc;
  word_t             seed_fold;
  word_t             result;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_first  <= COEF_FIRST_RST;
      coef_second <= COEF_SECOND_RST;
      coef_third  <= COEF_THIRD_RST;
      seed_value  <= SEED_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_FIRST:  coef_first  <= cfg_data[COEF_W-1:0];
        REG_COEF_SECOND: coef_second <= cfg_data[COEF_W-1:0];
        REG_COEF_THIRD:  coef_third  <= cfg_data[COEF_W-1:0];
        REG_SEED_VALUE:  seed_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !out_vld || m_tready;
  assign s_tready = !in_vld || adv;

  always_comb begin
    acc = ACC_W'({16'd0, coef_first}  * {16'd0, hist[0]})
        + ACC_W'({16'd0, coef_second} * {16'd0, hist[1]})
        + ACC_W'({16'd0, coef_third}  * {16'd0, hist[2]});
    seed_fold = fold_word(seed_value);
    result    = in_reseed ? seed_fold : mod_acc(acc);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_reseed <= s_tdata[0];
    end
  end

  // output register and history
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      hist[0] <= HIST_RESET;
      hist[1] <= HIST_RESET;
      hist[2] <= HIST_RESET;
    end else if (adv) begin
      out_vld <= in_vld;
      if (in_vld) begin
        hist[0] <= result;
        hist[1] <= in_reseed ? result : hist[0];
        hist[2] <= in_reseed ? result : hist[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = out_data;

  `TORRG_ASSERT_IMPL(a_out_residue, clk, rst, m_tvalid, m_tdata < MODULUS)
  `TORRG_ASSERT_IMPL(a_stall_cause, clk, rst, !s_tready,
                     in_vld && m_tvalid && !m_tready)
  `TORRG_ASSERT_NEXT(a_reseed_hist, clk, rst, adv && in_vld && in_reseed,
                     hist[0] == hist[1] && hist[1] == hist[2] && m_tdata == hist[0])
  `TORRG_ASSERT_NEXT(a_shift_hist, clk, rst, adv && in_vld && !in_reseed,
                     hist[1] == $past(hist[0]) && hist[2] == $past(hist[1]) &&
                     m_tdata == hist[0])

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the third-order recursive random generator core: stream checks against a local predictor.
`timescale 1ns / 100ps

module tb_top;
  import torrg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;   // [0] reseed, [7:1] zero
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;            // [31:0] random_value
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data  = 32'd0;

  // predictor copy of the generator: multipliers, seed and history (recent first)
  logic [15:0] mult_recent = COEF_FIRST_RST;
  logic [15:0] mult_mid    = COEF_SECOND_RST;
  logic [15:0] mult_oldest = COEF_THIRD_RST;
  word_t       seed_word   = SEED_RESET;
  word_t       hist_word [3] = '{HIST_RESET, HIST_RESET, HIST_RESET};

  word_t pending_values[$];
  word_t wanted_value;
  int    mismatch_count = 0;
  int    quiet_cycles   = 0;
  int    ready_hold     = 0;
  bit    idle_enabled   = 1'b1;

  third_order_recursive_random_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // next output of the generator; updates the predictor history
  function automatic word_t next_random_value(input bit reseed);
    logic [63:0] acc;
    word_t       nxt;
    if (reseed) begin
      nxt = (seed_word >= MODULUS) ? seed_word - MODULUS : seed_word;
      hist_word[0] = nxt;
      hist_word[1] = nxt;
      hist_word[2] = nxt;
    end else begin
      acc = 64'(mult_recent) * 64'(hist_word[0])
          + 64'(mult_mid) * 64'(hist_word[1])
          + 64'(mult_oldest) * 64'(hist_word[2]);
      nxt = 32'(acc % 64'(MODULUS));
      hist_word[2] = hist_word[1];
      hist_word[1] = hist_word[0];
      hist_word[0] = nxt;
    end
    return nxt;
  endfunction

  function automatic logic [31:0] pick_coef_data();
    logic [15:0] c;
    case ($urandom_range(0, 7))
      0: c = 16'hFFFF;
      1: c = 16'h0000;
      default: c = 16'($urandom);
    endcase
    // upper bits must be dropped by the block
    return {16'($urandom), c};
  endfunction

  function automatic word_t pick_seed();
    case ($urandom_range(0, 3))
      0: return MODULUS + 32'($urandom_range(0, 4));
      1: return 32'd0;
      default: return 32'($urandom);
    endcase
  endfunction

  // ready side: random stall bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      m_tready   <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_values.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected item random_value expected none actual %h", $time, m_tdata);
      end else begin
        wanted_value = pending_values.pop_front();
        if (m_tdata !== wanted_value) begin
          mismatch_count++;
          $display("%0t random_value mismatch expected %h actual %h",
                   $time, wanted_value, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back items; lowered only for a gap
  task automatic send_request(input bit reseed);
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, reseed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_values.push_back(next_random_value(reseed));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEF_FIRST:  mult_recent = value[15:0];
      REG_COEF_SECOND: mult_mid    = value[15:0];
      REG_COEF_THIRD:  mult_oldest = value[15:0];
      REG_SEED_VALUE:  seed_word   = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_settings(input logic [31:0] c1, input logic [31:0] c2,
                                  input logic [31:0] c3, input word_t seed);
    wait_drained();
    write_register(REG_COEF_FIRST, c1);
    write_register(REG_COEF_SECOND, c2);
    write_register(REG_COEF_THIRD, c3);
    write_register(REG_SEED_VALUE, seed);
  endtask

  task automatic test_reset_defaults();
    repeat (3) send_request(1'b0);
  endtask

  // seeds at or above the modulus fold; seed zero stays zero
  task automatic test_seed_folding();
    int k;
    for (k = 0; k < 5; k++) begin
      wait_drained();
      write_register(REG_SEED_VALUE, MODULUS + 32'(k));
      send_request(1'b1);
      send_request(1'b0);
    end
    wait_drained();
    write_register(REG_SEED_VALUE, 32'd0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_coef_extremes();
    // largest multipliers on the largest residue; all-ones data checks masking
    program_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MODULUS - 32'd1);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    // zero multipliers with junk in the upper bits
    program_settings(32'hABCD_0000, 32'h1234_0000, 32'hFFFF_0000, 32'hFFFF_FFFF);
    repeat (2) send_request(1'b0);
  endtask

  task automatic test_config_sweep(input int phases, input int per_phase);
    int p;
    int i;
    for (p = 0; p < phases; p++) begin
      program_settings(pick_coef_data(), pick_coef_data(), pick_coef_data(), pick_seed());
      send_request(1'($urandom_range(0, 1)));
      for (i = 1; i < per_phase; i++) send_request($urandom_range(0, 15) == 0);
    end
    program_settings({16'($urandom), COEF_FIRST_RST}, {16'($urandom), COEF_SECOND_RST},
                     {16'($urandom), COEF_THIRD_RST}, 32'($urandom));
  endtask

  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 40; i++) send_request($urandom_range(0, 15) == 0);
    wait_drained();
    for (i = 0; i < 40; i++) send_request($urandom_range(0, 15) == 0);
  endtask

  task automatic test_random_stream(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      // alternate stretches with and without idling; none near the end
      if (i % 64 == 0) idle_enabled = (count - i > 200) && ($urandom_range(0, 3) != 0);
      send_request($urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_seed_folding();
    test_coef_extremes();
    test_config_sweep(6, 100);
    test_drain_pause();
    test_random_stream(1000);
    idle_enabled = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_values.size() != 0) begin
      mismatch_count++;
      $display("%0t %0d items still expected", $time, pending_values.size());
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
